/* design/adq_pkg.sv */
// Shared command codes, status codes and controller-to-datapath command bundle.
package adq_pkg;

    localparam logic [2:0] CMD_ADD_LAST  = 3'd0;
    localparam logic [2:0] CMD_DEL_LAST  = 3'd1;
    localparam logic [2:0] CMD_ADD_FIRST = 3'd2;
    localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
    localparam logic [2:0] CMD_REPORT    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;   // take a command transaction and update indices and storage
        logic read;     // launch reads of the front and back entries
        logic load;     // move the step result into the response register
    } adq_ctl_t;

endpackage

/* design/adq_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module adq_ram
#(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* design/adq_ctrl.sv */
// Sequencing state machine: accept, read back, load response.
module adq_ctrl
    import adq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output adq_ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // response slot frees up when empty or when its transaction completes now
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctl.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* design/adq_datapath.sv */
// Index registers, ring-addressed storage and response registers.
module adq_datapath
    import adq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  adq_ctl_t           ctl,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    output logic [1:0]         status,
    output logic signed [31:0] first_value,
    output logic signed [31:0] last_value,
    output logic [4:0]         item_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);

    logic [IW-1:0]         front_reg;
    logic [IW-1:0]         front_next;
    logic [IW-1:0]         rear_reg;
    logic [IW-1:0]         rear_next;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [1:0]            step_status_reg;
    logic [1:0]            step_status_next;

    logic [IW-1:0]         count;
    logic                  full;
    logic                  empty;
    logic [AW:0]           tail_sum;
    logic [AW:0]           last_sum;
    logic [AW-1:0]         tail_addr;
    logic [AW-1:0]         last_addr;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data_a;
    logic [DATA_WIDTH-1:0] rd_data_b;

    logic [1:0]            status_reg;
    logic signed [31:0]    first_reg;
    logic signed [31:0]    last_reg;
    logic [4:0]            count_reg;

    assign count = rear_reg - front_reg;
    assign full  = (rear_reg == IW'(DEPTH));
    assign empty = (front_reg == rear_reg);

    // physical slots wrap at DEPTH; sums stay below twice DEPTH
    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(count);
    assign last_sum  = tail_sum - (AW+1)'(1);
    assign tail_addr = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                     : AW'(tail_sum);
    assign last_addr = (last_sum >= (AW+1)'(DEPTH)) ? AW'(last_sum - (AW+1)'(DEPTH))
                                                     : AW'(last_sum);
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    assign wr_data = DATA_WIDTH'(value);

    always_comb
    begin
        front_next       = front_reg;
        rear_next        = rear_reg;
        head_next        = head_reg;
        step_status_next = step_status_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_addr;
        if (ctl.accept)
        begin
            step_status_next = ST_OK;
            unique case (command)
                CMD_ADD_LAST:
                begin
                    if (full)
                    begin
                        step_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        rear_next = rear_reg + IW'(1);
                    end
                end
                CMD_DEL_LAST:
                begin
                    if (empty)
                    begin
                        step_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rear_next = rear_reg - IW'(1);
                    end
                end
                CMD_ADD_FIRST:
                begin
                    if (full)
                    begin
                        step_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = head_dec;
                        head_next = head_dec;
                        rear_next = rear_reg + IW'(1);
                    end
                end
                CMD_DEL_FIRST:
                begin
                    if (empty)
                    begin
                        step_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        front_next = front_reg + IW'(1);
                        head_next  = head_inc;
                    end
                end
                default:
                begin
                    step_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            rear_reg        <= '0;
            head_reg        <= '0;
            step_status_reg <= ST_OK;
        end
        else
        begin
            front_reg       <= front_next;
            rear_reg        <= rear_next;
            head_reg        <= head_next;
            step_status_reg <= step_status_next;
        end
    end

    adq_ram
    #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (ctl.read),
        .rd_addr_a (head_reg),
        .rd_addr_b (last_addr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // response payload; sign-extend stored entries from DATA_WIDTH
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            status_reg <= step_status_reg;
            count_reg  <= 5'(count);
            if (empty)
            begin
                first_reg <= '0;
                last_reg  <= '0;
            end
            else
            begin
                first_reg <= 32'(signed'(rd_data_a));
                last_reg  <= 32'(signed'(rd_data_b));
            end
        end
    end

    assign status      = status_reg;
    assign first_value = first_reg;
    assign last_value  = last_reg;
    assign item_count  = count_reg;

endmodule

/* design/array_double_ended_queue.sv */
// Array deque: one command transaction in, one status/front/back/count transaction out.
// Each command steps through accept, storage read and response load in order, and a new
// command is taken only after the response load; the read step comes from the registered read
// of the storage RAM, and a stalled response holds the load step.
// Reset (rst_n, async, active low) clears indices, state machine and response valid;
// storage contents are not cleared and no clearing pass is needed.
module array_double_ended_queue
    import adq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] first_value,
    output logic signed [31:0] last_value,
    output logic [4:0]         item_count
);

    adq_ctl_t ctl;

    // Controller: stall the command channel from accept until the response
    // register has taken the result, so only one transaction is in flight.
    adq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // Datapath: the logical deque lives in a ring of DEPTH slots. Add-first
    // steps the ring head back instead of shifting entries, which gives the
    // same front/back contents; the front and rear indices still follow the
    // linear-array rules, so "full" means rear reached DEPTH.
    adq_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .value       (value),
        .status      (status),
        .first_value (first_value),
        .last_value  (last_value),
        .item_count  (item_count)
    );

    // One transaction at a time: the cycle after an accept, the command side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted while previous transaction in flight");

    // A refused delete means the queue was and stays empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |->
            (item_count == 5'd0 && first_value == 32'sd0 && last_value == 32'sd0))
        else $error("empty status with nonempty response");

    // A response is loaded only while the command side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> cmd_stall)
        else $error("response load outside of transaction");

endmodule
